// File: hw/rtl/draw_command_stream_decoder_defines.svh
// Assertion macros for the draw command stream decoder.
`ifndef DRAW_COMMAND_STREAM_DECODER_DEFINES_SVH
`define DRAW_COMMAND_STREAM_DECODER_DEFINES_SVH
`ifndef ASSERT_OFF
`define DCSD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`define DCSD_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define DCSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define DCSD_ASSERT_NEVER(lbl, cond, msg)
`define DCSD_ASSERT_IMPLY(lbl, ante, cons, msg)
`define DCSD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: hw/rtl/dcsd_pkg.sv
// Types, codes and helpers for the draw command stream decoder.
`default_nettype none
package dcsd_pkg;

  typedef enum logic [3:0] {
    K_RES   = 4'd0,
    K_BG    = 4'd1,
    K_FG    = 4'd2,
    K_FILL  = 4'd3,
    K_LINE  = 4'd4,
    K_BEGIN = 4'd5,
    K_CELL  = 4'd6,
    K_END   = 4'd7,
    K_SYNC  = 4'd8,
    K_ERR   = 4'd9
  } op_kind_t;

  localparam logic [7:0] OP_SYNC      = 8'h01;
  localparam logic [7:0] OP_RECT      = 8'h10;
  localparam logic [7:0] OP_LIT_H     = 8'h12;
  localparam logic [7:0] OP_LIT_V     = 8'h13;
  localparam logic [7:0] OP_HFILL     = 8'h18;
  localparam logic [7:0] OP_VFILL     = 8'h19;
  localparam logic [7:0] OP_RUN_H     = 8'h22;
  localparam logic [7:0] OP_RUN_V     = 8'h23;
  localparam logic [7:0] RUN_REP_BASE = 8'hA0;
  localparam logic [7:0] GLYPH_FULL   = 8'd255;
  localparam logic [7:0] GLYPH_EMPTY  = 8'd0;
  localparam int unsigned MAX_RES     = 4;
  localparam int unsigned NUM_ARGS    = 5;

  typedef enum logic [8:0] {
    PH_HDR0   = 9'b000000001,
    PH_HDR1   = 9'b000000010,
    PH_HDR2   = 9'b000000100,
    PH_OP     = 9'b000001000,
    PH_ARGS   = 9'b000010000,
    PH_LIT    = 9'b000100000,
    PH_RUNHDR = 9'b001000000,
    PH_RUNVAL = 9'b010000000,
    PH_RUNLIT = 9'b100000000
  } phase_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [8:0]  x;
    logic [8:0]  y;
    logic [7:0]  w;
    logic [7:0]  h;
    logic [7:0]  col;
    logic [7:0]  gl;
    logic        vert;
    logic [6:0]  rep;
  } res_t;

  function automatic res_t make_res(op_kind_t kind, logic [8:0] x, logic [8:0] y,
                                    logic [7:0] w, logic [7:0] h, logic [7:0] col,
                                    logic [7:0] gl, logic vert, logic [6:0] rep);
    res_t r;
    r.kind = kind;
    r.x    = x;
    r.y    = y;
    r.w    = w;
    r.h    = h;
    r.col  = col;
    r.gl   = gl;
    r.vert = vert;
    r.rep  = rep;
    return r;
  endfunction

  // argument bytes per opcode, zero for SYNC and unknown opcodes
  function automatic logic [2:0] args_needed(logic [7:0] op);
    logic [2:0] n;
    case (op)
      OP_RECT, OP_LIT_H, OP_LIT_V: n = 3'd5;
      OP_HFILL, OP_VFILL, OP_RUN_H, OP_RUN_V: n = 3'd4;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/draw_command_stream_decoder.sv
// Draw command stream decoder: one stream byte in, up to four draw words out.
// Each byte is parsed in the cycle it is accepted; its words appear on the
// output in the next cycle and drain from a 4-entry buffer at one word per
// cycle while out_stall is low. Throughput is one byte per cycle when a byte
// yields at most one word and out_stall is low; more words hold in_stall high.
// Synchronous reset returns the parser to the header and clears colors/halt.
`default_nettype none
`include "draw_command_stream_decoder_defines.svh"
module draw_command_stream_decoder (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output      logic                 in_stall,
  input  wire logic [7:0]           stream_byte,
  output      logic                 out_valid,
  input  wire logic                 out_stall,
  output      logic [3:0]           op_kind,
  output      logic [8:0]           x_pos,
  output      logic [8:0]           y_pos,
  output      logic [7:0]           width_out,
  output      logic [7:0]           height_out,
  output      logic [7:0]           color_index,
  output      logic [7:0]           glyph_index,
  output      logic                 vertical,
  output      logic [6:0]           repeat_count,
  output      logic                 last
);
  import dcsd_pkg::*;

  // parser state
  phase_t     phase, phase_next;
  logic [7:0] opcode, opcode_next;
  logic [7:0] args [NUM_ARGS];
  logic [7:0] args_next [NUM_ARGS];
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] bg, bg_next;
  logic [7:0] fg, fg_next;
  logic       invert, invert_next;
  logic       halted, halted_next;

  // result buffer
  res_t       res_buf [MAX_RES];
  logic [2:0] count;
  logic [2:0] rd;

  res_t       r [MAX_RES];
  logic [2:0] cnt;

  logic       in_fire, out_fire;
  logic [2:0] rd_inc;

  logic [2:0] need, idx;
  logic [7:0] left_dec;
  logic [7:0] fw, fh, fc, rbg, rfg;
  logic [7:0] cell_gl;
  logic [8:0] ax1, ay1;

  assign rd_inc    = rd + 3'd1;
  assign out_valid = (rd < count);
  assign out_fire  = out_valid && !out_stall;
  assign in_stall  = out_valid && !(out_fire && (rd_inc == count));
  assign in_fire   = in_valid && !in_stall;

  always_comb begin
    need     = args_needed(opcode);
    idx      = need - bytes_left[2:0];
    left_dec = bytes_left - 8'd1;
    cell_gl  = invert ? ~stream_byte : stream_byte;

    phase_next      = phase;
    opcode_next     = opcode;
    bytes_left_next = bytes_left;
    bg_next         = bg;
    fg_next         = fg;
    invert_next     = invert;
    halted_next     = halted;
    for (int i = 0; i < NUM_ARGS; i++) begin
      args_next[i] = args[i];
    end
    for (int i = 0; i < MAX_RES; i++) begin
      r[i] = '0;
    end
    cnt = 3'd0;
    fw  = 8'd0;
    fh  = 8'd0;
    fc  = 8'd0;
    rbg = 8'd0;
    rfg = 8'd0;
    ax1 = 9'd0;
    ay1 = 9'd0;

    if (!halted) begin
      case (phase)
        PH_HDR0: phase_next = PH_HDR1;
        PH_HDR1: begin
          args_next[0] = stream_byte;
          phase_next   = PH_HDR2;
        end
        PH_HDR2: begin
          r[cnt[1:0]] = make_res(K_RES, 9'd0, 9'd0, args[0], stream_byte, 8'd0, 8'd0,
                                 1'b0, 7'd0);
          cnt = cnt + 3'd1;
          phase_next = PH_OP;
        end
        PH_OP: begin
          opcode_next = stream_byte;
          if (stream_byte == OP_SYNC) begin
            r[cnt[1:0]] = make_res(K_SYNC, 9'd0, 9'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 7'd0);
            cnt = cnt + 3'd1;
          end else if (args_needed(stream_byte) == 3'd0) begin
            r[cnt[1:0]] = make_res(K_ERR, 9'd0, 9'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 7'd0);
            cnt = cnt + 3'd1;
            halted_next = 1'b1;
          end else begin
            bytes_left_next = {5'd0, args_needed(stream_byte)};
            phase_next      = PH_ARGS;
          end
        end
        PH_ARGS: begin
          if (idx < 3'd5) args_next[idx] = stream_byte;
          bytes_left_next = left_dec;
          if (left_dec == 8'd0) begin
            ax1 = {1'b0, args_next[0]} + 9'd1;
            ay1 = {1'b0, args_next[1]} + 9'd1;
            if (opcode == OP_RECT || opcode == OP_HFILL || opcode == OP_VFILL) begin
              // fill family: pick size and color per opcode
              if (opcode == OP_RECT) begin
                fw = args_next[2];
                fh = args_next[3];
                fc = args_next[4];
              end else if (opcode == OP_HFILL) begin
                fw = args_next[2];
                fh = 8'd1;
                fc = args_next[3];
              end else begin
                fw = 8'd1;
                fh = args_next[2];
                fc = args_next[3];
              end
              if (fg != fc && bg != fc) begin
                r[cnt[1:0]] = make_res(K_BG, 9'd0, 9'd0, 8'd0, 8'd0, fc, 8'd0, 1'b0, 7'd0);
                cnt = cnt + 3'd1;
                bg_next = fc;
              end
              if (fw >= 8'd2 && fh >= 8'd2) begin
                r[cnt[1:0]] = make_res(K_FILL, ax1, ay1, fw, fh, 8'd0,
                                       (fg == fc) ? GLYPH_FULL : GLYPH_EMPTY, 1'b0, 7'd0);
              end else if (fw > 8'd1) begin
                r[cnt[1:0]] = make_res(K_LINE, ax1, ay1, fw, 8'd0, 8'd0,
                                       (fg == fc) ? GLYPH_FULL : GLYPH_EMPTY, 1'b0, 7'd0);
              end else begin
                r[cnt[1:0]] = make_res(K_LINE, ax1, ay1, fh, 8'd0, 8'd0,
                                       (fg == fc) ? GLYPH_FULL : GLYPH_EMPTY, 1'b1, 7'd0);
              end
              cnt = cnt + 3'd1;
              phase_next = PH_OP;
            end else begin
              // glyph rows: literal rows carry a width byte before the colors
              if (opcode == OP_LIT_H || opcode == OP_LIT_V) begin
                rbg = args_next[3];
                rfg = args_next[4];
              end else begin
                rbg = args_next[2];
                rfg = args_next[3];
              end
              invert_next = 1'b0;
              if (rbg == bg && rfg == fg) begin
                invert_next = 1'b0;
              end else if (rbg == fg && rfg == bg) begin
                invert_next = 1'b1;
              end else if (rbg == bg) begin
                r[cnt[1:0]] = make_res(K_FG, 9'd0, 9'd0, 8'd0, 8'd0, rfg, 8'd0, 1'b0, 7'd0);
                cnt = cnt + 3'd1;
                fg_next = rfg;
              end else if (rfg == bg) begin
                r[cnt[1:0]] = make_res(K_FG, 9'd0, 9'd0, 8'd0, 8'd0, rbg, 8'd0, 1'b0, 7'd0);
                cnt = cnt + 3'd1;
                fg_next     = rbg;
                invert_next = 1'b1;
              end else if (rfg == fg) begin
                r[cnt[1:0]] = make_res(K_BG, 9'd0, 9'd0, 8'd0, 8'd0, rbg, 8'd0, 1'b0, 7'd0);
                cnt = cnt + 3'd1;
                bg_next = rbg;
              end else if (rbg == fg) begin
                r[cnt[1:0]] = make_res(K_BG, 9'd0, 9'd0, 8'd0, 8'd0, rfg, 8'd0, 1'b0, 7'd0);
                cnt = cnt + 3'd1;
                bg_next     = rfg;
                invert_next = 1'b1;
              end else begin
                r[cnt[1:0]] = make_res(K_BG, 9'd0, 9'd0, 8'd0, 8'd0, rbg, 8'd0, 1'b0, 7'd0);
                cnt = cnt + 3'd1;
                r[cnt[1:0]] = make_res(K_FG, 9'd0, 9'd0, 8'd0, 8'd0, rfg, 8'd0, 1'b0, 7'd0);
                cnt = cnt + 3'd1;
                bg_next = rbg;
                fg_next = rfg;
              end
              r[cnt[1:0]] = make_res(K_BEGIN, ax1, ay1, 8'd0, 8'd0, 8'd0, 8'd0, opcode[0],
                                     7'd0);
              cnt = cnt + 3'd1;
              if (opcode == OP_LIT_H || opcode == OP_LIT_V) begin
                if (args_next[2] == 8'd0) begin
                  r[cnt[1:0]] = make_res(K_END, 9'd0, 9'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0,
                                         7'd0);
                  cnt = cnt + 3'd1;
                  phase_next = PH_OP;
                end else begin
                  bytes_left_next = args_next[2];
                  phase_next      = PH_LIT;
                end
              end else begin
                phase_next = PH_RUNHDR;
              end
            end
          end
        end
        PH_LIT: begin
          r[cnt[1:0]] = make_res(K_CELL, 9'd0, 9'd0, 8'd0, 8'd0, 8'd0, cell_gl, 1'b0, 7'd1);
          cnt = cnt + 3'd1;
          bytes_left_next = left_dec;
          if (left_dec == 8'd0) begin
            r[cnt[1:0]] = make_res(K_END, 9'd0, 9'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 7'd0);
            cnt = cnt + 3'd1;
            phase_next = PH_OP;
          end
        end
        PH_RUNHDR: begin
          if (stream_byte == 8'd0) begin
            r[cnt[1:0]] = make_res(K_END, 9'd0, 9'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 7'd0);
            cnt = cnt + 3'd1;
            phase_next = PH_OP;
          end else if (stream_byte > RUN_REP_BASE) begin
            bytes_left_next = stream_byte - RUN_REP_BASE;
            phase_next      = PH_RUNVAL;
          end else begin
            bytes_left_next = stream_byte;
            phase_next      = PH_RUNLIT;
          end
        end
        PH_RUNVAL: begin
          r[cnt[1:0]] = make_res(K_CELL, 9'd0, 9'd0, 8'd0, 8'd0, 8'd0, cell_gl, 1'b0,
                                 bytes_left[6:0]);
          cnt = cnt + 3'd1;
          phase_next = PH_RUNHDR;
        end
        PH_RUNLIT: begin
          r[cnt[1:0]] = make_res(K_CELL, 9'd0, 9'd0, 8'd0, 8'd0, 8'd0, cell_gl, 1'b0, 7'd1);
          cnt = cnt + 3'd1;
          bytes_left_next = left_dec;
          if (left_dec == 8'd0) phase_next = PH_RUNHDR;
        end
        default: phase_next = PH_OP;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HDR0;
      opcode     <= 8'd0;
      bytes_left <= 8'd0;
      bg         <= 8'd0;
      fg         <= 8'd0;
      invert     <= 1'b0;
      halted     <= 1'b0;
      for (int i = 0; i < NUM_ARGS; i++) begin
        args[i] <= 8'd0;
      end
    end else if (in_fire) begin
      phase      <= phase_next;
      opcode     <= opcode_next;
      bytes_left <= bytes_left_next;
      bg         <= bg_next;
      fg         <= fg_next;
      invert     <= invert_next;
      halted     <= halted_next;
      for (int i = 0; i < NUM_ARGS; i++) begin
        args[i] <= args_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 3'd0;
      rd    <= 3'd0;
    end else if (in_fire) begin
      count <= cnt;
      rd    <= 3'd0;
    end else if (out_fire) begin
      if (rd_inc == count) begin
        count <= 3'd0;
        rd    <= 3'd0;
      end else begin
        rd <= rd_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < MAX_RES; i++) begin
        res_buf[i] <= r[i];
      end
    end
  end

  assign op_kind      = res_buf[rd[1:0]].kind;
  assign x_pos        = res_buf[rd[1:0]].x;
  assign y_pos        = res_buf[rd[1:0]].y;
  assign width_out    = res_buf[rd[1:0]].w;
  assign height_out   = res_buf[rd[1:0]].h;
  assign color_index  = res_buf[rd[1:0]].col;
  assign glyph_index  = res_buf[rd[1:0]].gl;
  assign vertical     = res_buf[rd[1:0]].vert;
  assign repeat_count = res_buf[rd[1:0]].rep;
  assign last         = (rd_inc == count);

  `DCSD_ASSERT_NEVER(a_count_range, count > 3'd4, "result count above buffer depth")
  `DCSD_ASSERT_IMPLY(a_no_overrun, in_fire, (count - rd) <= 3'd1, "byte taken over pending words")
  `DCSD_ASSERT_NEXT(a_halt_sticky, halted, halted, "halt cleared without reset")
  `DCSD_ASSERT_NEXT(a_words_shown, in_fire && cnt != 3'd0, out_valid, "words not presented")

endmodule
`default_nettype wire

// File: tb/tb_draw_command_stream_decoder.sv
// Self-checking testbench for the draw command stream decoder.
module tb_draw_command_stream_decoder;
  import dcsd_pkg::*;

  localparam int DIR_ROWS     = 25;
  localparam int RANDOM_BYTES = 430;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int REPORT_MAX   = 10;
  localparam logic [7:0] RUN_END = 8'h00;

  typedef enum {
    PS_HDR0, PS_HDR1, PS_HDR2, PS_OPCODE, PS_ARGS,
    PS_LIT, PS_RUN_HDR, PS_RUN_VAL, PS_RUN_LIT
  } parse_state_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [8:0] x;
    logic [8:0] y;
    logic [7:0] w;
    logic [7:0] h;
    logic [7:0] col;
    logic [7:0] gl;
    logic       vert;
    logic [6:0] rep;
    logic       last;
  } draw_word_t;

  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    draw_word_t want;
  } stream_entry_t;

  localparam draw_word_t NO_DRAW = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] stream_byte = 8'h00;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [3:0] op_kind;
  logic [8:0] x_pos;
  logic [8:0] y_pos;
  logic [7:0] width_out;
  logic [7:0] height_out;
  logic [7:0] color_index;
  logic [7:0] glyph_index;
  logic vertical;
  logic [6:0] repeat_count;
  logic last;

  draw_command_stream_decoder u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stream_byte(stream_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .op_kind(op_kind),
    .x_pos(x_pos),
    .y_pos(y_pos),
    .width_out(width_out),
    .height_out(height_out),
    .color_index(color_index),
    .glyph_index(glyph_index),
    .vertical(vertical),
    .repeat_count(repeat_count),
    .last(last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // decoder state mirror
  parse_state_t pstate;
  logic [7:0] cur_op;
  logic [7:0] cmd_args [5];
  int arg_pos;
  int arg_need;
  logic [7:0] res_width;
  logic [7:0] glyphs_left;
  logic [7:0] bg_cache;
  logic [7:0] fg_cache;
  logic swap_glyphs;
  logic halted_p;
  draw_word_t byte_words[$];

  stream_entry_t dir_tab [DIR_ROWS];
  stream_entry_t byte_stream[$];
  draw_word_t pending_draws[$];
  int feed_idx = 0;
  int mismatch_cnt = 0;
  int cycle_cnt = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_hold = 0;
  logic [15:0] stall_pat = '0;

  function automatic draw_word_t draw_word(op_kind_t kind, logic [8:0] x, logic [8:0] y,
                                           logic [7:0] w, logic [7:0] h, logic [7:0] col,
                                           logic [7:0] gl, logic vert, logic [6:0] rep);
    draw_word_t d;
    d.kind = kind;
    d.x    = x;
    d.y    = y;
    d.w    = w;
    d.h    = h;
    d.col  = col;
    d.gl   = gl;
    d.vert = vert;
    d.rep  = rep;
    d.last = 1'b1;
    return d;
  endfunction

  function automatic string word_text(draw_word_t d);
    return $sformatf("kind=%0d x=%0d y=%0d w=%0d h=%0d col=%0d gl=%0d vert=%0d rep=%0d last=%0d",
                     d.kind, d.x, d.y, d.w, d.h, d.col, d.gl, d.vert, d.rep, d.last);
  endfunction

  function void reset_decoder_state();
    pstate      = PS_HDR0;
    cur_op      = '0;
    arg_pos     = 0;
    arg_need    = 0;
    res_width   = '0;
    glyphs_left = '0;
    bg_cache    = '0;
    fg_cache    = '0;
    swap_glyphs = 1'b0;
    halted_p    = 1'b0;
    foreach (cmd_args[i]) cmd_args[i] = '0;
  endfunction

  function void add_draw(op_kind_t kind, logic [8:0] x, logic [8:0] y, logic [7:0] w,
                         logic [7:0] h, logic [7:0] col, logic [7:0] gl, logic vert,
                         logic [6:0] rep);
    draw_word_t d;
    d = draw_word(kind, x, y, w, h, col, gl, vert, rep);
    d.last = 1'b0;
    byte_words.push_back(d);
  endfunction

  function void set_bg(logic [7:0] c);
    if (c != bg_cache) begin
      add_draw(K_BG, '0, '0, '0, '0, c, '0, 1'b0, '0);
      bg_cache = c;
    end
  endfunction

  function void set_fg(logic [7:0] c);
    if (c != fg_cache) begin
      add_draw(K_FG, '0, '0, '0, '0, c, '0, 1'b0, '0);
      fg_cache = c;
    end
  endfunction

  function void fill_area(logic [7:0] x, logic [7:0] y, logic [7:0] w, logic [7:0] h,
                          logic [7:0] c);
    logic [7:0] gl;
    logic [8:0] px;
    logic [8:0] py;
    px = {1'b0, x} + 9'd1;
    py = {1'b0, y} + 9'd1;
    gl = GLYPH_EMPTY;
    if (fg_cache == c) gl = GLYPH_FULL;
    else if (bg_cache != c) set_bg(c);
    if (w >= 8'd2 && h >= 8'd2) add_draw(K_FILL, px, py, w, h, '0, gl, 1'b0, '0);
    else if (w > 8'd1) add_draw(K_LINE, px, py, w, '0, '0, gl, 1'b0, '0);
    else add_draw(K_LINE, px, py, h, '0, '0, gl, 1'b1, '0);
  endfunction

  // choose the cheapest color setup; swapped colors mean every glyph is inverted
  function void pick_row_colors(logic [7:0] bg, logic [7:0] fg);
    logic [7:0] cb;
    logic [7:0] cf;
    cb = bg_cache;
    cf = fg_cache;
    swap_glyphs = 1'b0;
    if (bg == cb && fg == cf) begin
    end else if (bg == cf && fg == cb) begin
      swap_glyphs = 1'b1;
    end else if (bg == cb) begin
      set_fg(fg);
    end else if (fg == cb) begin
      set_fg(bg);
      swap_glyphs = 1'b1;
    end else if (fg == cf) begin
      set_bg(bg);
    end else if (bg == cf) begin
      set_bg(fg);
      swap_glyphs = 1'b1;
    end else begin
      set_bg(bg);
      set_fg(fg);
    end
  endfunction

  function void add_cell(logic [7:0] g, logic [6:0] rep);
    add_draw(K_CELL, '0, '0, '0, '0, '0, swap_glyphs ? ~g : g, 1'b0, rep);
  endfunction

  function void start_row(logic [7:0] bg, logic [7:0] fg);
    pick_row_colors(bg, fg);
    add_draw(K_BEGIN, {1'b0, cmd_args[0]} + 9'd1, {1'b0, cmd_args[1]} + 9'd1, '0, '0, '0,
             '0, cur_op[0], '0);
  endfunction

  function void finish_command();
    pstate = PS_OPCODE;
    case (cur_op)
      OP_RECT: fill_area(cmd_args[0], cmd_args[1], cmd_args[2], cmd_args[3], cmd_args[4]);
      OP_HFILL: fill_area(cmd_args[0], cmd_args[1], cmd_args[2], 8'd1, cmd_args[3]);
      OP_VFILL: fill_area(cmd_args[0], cmd_args[1], 8'd1, cmd_args[2], cmd_args[3]);
      OP_LIT_H, OP_LIT_V: begin
        start_row(cmd_args[3], cmd_args[4]);
        if (cmd_args[2] == 8'd0) begin
          add_draw(K_END, '0, '0, '0, '0, '0, '0, 1'b0, '0);
        end else begin
          glyphs_left = cmd_args[2];
          pstate = PS_LIT;
        end
      end
      default: begin
        start_row(cmd_args[2], cmd_args[3]);
        pstate = PS_RUN_HDR;
      end
    endcase
  endfunction

  // words the decoder owes for one accepted stream byte
  function void decode_stream_byte(logic [7:0] b);
    byte_words.delete();
    if (!halted_p) begin
      case (pstate)
        PS_HDR0: pstate = PS_HDR1;
        PS_HDR1: begin
          res_width = b;
          pstate = PS_HDR2;
        end
        PS_HDR2: begin
          add_draw(K_RES, '0, '0, res_width, b, '0, '0, 1'b0, '0);
          pstate = PS_OPCODE;
        end
        PS_OPCODE: begin
          cur_op = b;
          arg_pos = 0;
          case (b)
            OP_SYNC: add_draw(K_SYNC, '0, '0, '0, '0, '0, '0, 1'b0, '0);
            OP_RECT, OP_LIT_H, OP_LIT_V: begin
              arg_need = 5;
              pstate = PS_ARGS;
            end
            OP_HFILL, OP_VFILL, OP_RUN_H, OP_RUN_V: begin
              arg_need = 4;
              pstate = PS_ARGS;
            end
            default: begin
              add_draw(K_ERR, '0, '0, '0, '0, '0, '0, 1'b0, '0);
              halted_p = 1'b1;
            end
          endcase
        end
        PS_ARGS: begin
          cmd_args[arg_pos] = b;
          arg_pos++;
          if (arg_pos == arg_need) finish_command();
        end
        PS_LIT: begin
          add_cell(b, 7'd1);
          glyphs_left--;
          if (glyphs_left == 8'd0) begin
            add_draw(K_END, '0, '0, '0, '0, '0, '0, 1'b0, '0);
            pstate = PS_OPCODE;
          end
        end
        PS_RUN_HDR: begin
          if (b == RUN_END) begin
            add_draw(K_END, '0, '0, '0, '0, '0, '0, 1'b0, '0);
            pstate = PS_OPCODE;
          end else if (b > RUN_REP_BASE) begin
            glyphs_left = b - RUN_REP_BASE;
            pstate = PS_RUN_VAL;
          end else begin
            glyphs_left = b;
            pstate = PS_RUN_LIT;
          end
        end
        PS_RUN_VAL: begin
          add_cell(b, glyphs_left[6:0]);
          pstate = PS_RUN_HDR;
        end
        default: begin
          add_cell(b, 7'd1);
          glyphs_left--;
          if (glyphs_left == 8'd0) pstate = PS_RUN_HDR;
        end
      endcase
      if (byte_words.size() != 0) byte_words[byte_words.size() - 1].last = 1'b1;
    end
  endfunction

  function void take_byte(stream_entry_t e);
    decode_stream_byte(e.b);
    if (e.typed) pending_draws.push_back(e.want);
    else foreach (byte_words[i]) pending_draws.push_back(byte_words[i]);
  endfunction

  function void push_byte(logic [7:0] b);
    stream_entry_t e;
    e = '0;
    e.b = b;
    byte_stream.push_back(e);
  endfunction

  function automatic logic [7:0] rand_color();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      2, 3: return 8'($urandom_range(1, 3));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] rand_size();
    case ($urandom_range(0, 6))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd2;
      3: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // glyph data sometimes looks like an opcode; it must still be taken as data
  function automatic logic [7:0] rand_glyph();
    case ($urandom_range(0, 9))
      0: return OP_RECT;
      1: return OP_SYNC;
      2: return RUN_END;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void add_random_command();
    int sel;
    int n;
    logic [7:0] op;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      push_byte(OP_SYNC);
    end else if (sel < 45) begin
      case ($urandom_range(0, 2))
        0: begin
          push_byte(OP_RECT);
          push_byte(rand_coord());
          push_byte(rand_coord());
          push_byte(rand_size());
          push_byte(rand_size());
        end
        1: begin
          push_byte(OP_HFILL);
          push_byte(rand_coord());
          push_byte(rand_coord());
          push_byte(rand_size());
        end
        default: begin
          push_byte(OP_VFILL);
          push_byte(rand_coord());
          push_byte(rand_coord());
          push_byte(rand_size());
        end
      endcase
      push_byte(rand_color());
    end else if (sel < 70) begin
      op = ($urandom_range(0, 1) != 0) ? OP_LIT_V : OP_LIT_H;
      if ($urandom_range(0, 39) == 0) n = 255;
      else if ($urandom_range(0, 3) == 0) n = $urandom_range(7, 20);
      else n = $urandom_range(0, 6);
      push_byte(op);
      push_byte(rand_coord());
      push_byte(rand_coord());
      push_byte(8'(n));
      push_byte(rand_color());
      push_byte(rand_color());
      repeat (n) push_byte(rand_glyph());
    end else begin
      op = ($urandom_range(0, 1) != 0) ? OP_RUN_V : OP_RUN_H;
      push_byte(op);
      push_byte(rand_coord());
      push_byte(rand_coord());
      push_byte(rand_color());
      push_byte(rand_color());
      repeat ($urandom_range(0, 4)) begin
        if ($urandom_range(0, 1) != 0) begin
          case ($urandom_range(0, 5))
            0: push_byte(RUN_REP_BASE + 8'd1);
            1: push_byte(8'hFF);
            default: push_byte(8'($urandom_range(RUN_REP_BASE + 1, 255)));
          endcase
          push_byte(rand_glyph());
        end else begin
          if ($urandom_range(0, 29) == 0) n = RUN_REP_BASE;
          else n = $urandom_range(1, 6);
          push_byte(8'(n));
          repeat (n) push_byte(rand_glyph());
        end
      end
      push_byte(RUN_END);
    end
  endfunction

  always @(posedge clk) begin
    draw_word_t got;
    cycle_cnt++;
    if (rst) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        take_byte(byte_stream[feed_idx]);
        feed_idx++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0 || feed_idx >= byte_stream.size()) begin
          in_valid <= 1'b0;
          if (gap_left != 0) gap_left--;
        end else begin
          in_valid <= 1'b1;
          stream_byte <= byte_stream[feed_idx].b;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          end
        end
      end

      if (out_valid && !out_stall) begin
        got.kind = op_kind_t'(op_kind);
        got.x    = x_pos;
        got.y    = y_pos;
        got.w    = width_out;
        got.h    = height_out;
        got.col  = color_index;
        got.gl   = glyph_index;
        got.vert = vertical;
        got.rep  = repeat_count;
        got.last = last;
        if (pending_draws.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX)
            $display("cycle %0d: unexpected word %s", cycle_cnt, word_text(got));
        end else begin
          if (got !== pending_draws[0]) begin
            mismatch_cnt++;
            if (mismatch_cnt <= REPORT_MAX)
              $display("cycle %0d: mismatch\n  exp %s\n  got %s", cycle_cnt,
                       word_text(pending_draws[0]), word_text(got));
          end
          void'(pending_draws.pop_front());
        end
      end

      if (stall_hold == 0) begin
        stall_hold = 32;
        case ($urandom_range(0, 3))
          0: stall_pat = '0;
          1: stall_pat = 16'($urandom);
          2: stall_pat = 16'($urandom & $urandom & $urandom);
          default: stall_pat = 16'hF000 >> $urandom_range(0, 12);
        endcase
      end
      stall_hold--;
      out_stall <= stall_pat[cycle_cnt % 16];
    end
  end

  initial begin
    logic [7:0] bad_op;
    reset_decoder_state();
    dir_tab = '{
      '{8'h5A, 1'b0, NO_DRAW},  // header, first byte ignored
      '{8'hFF, 1'b0, NO_DRAW},
      '{8'h00, 1'b1, draw_word(K_RES, '0, '0, 8'd255, 8'd0, '0, '0, 1'b0, '0)},
      '{OP_SYNC, 1'b1, draw_word(K_SYNC, '0, '0, '0, '0, '0, '0, 1'b0, '0)},
      // zero-height fill at the far corner in the foreground color
      '{OP_VFILL, 1'b0, NO_DRAW},
      '{8'hFF, 1'b0, NO_DRAW},
      '{8'hFF, 1'b0, NO_DRAW},
      '{8'h00, 1'b0, NO_DRAW},
      '{8'h00, 1'b1, draw_word(K_LINE, 9'd256, 9'd256, 8'd0, 8'd0, '0, GLYPH_FULL, 1'b1, '0)},
      // empty literal row
      '{OP_LIT_H, 1'b0, NO_DRAW},
      '{8'h00, 1'b0, NO_DRAW},
      '{8'h00, 1'b0, NO_DRAW},
      '{8'h00, 1'b0, NO_DRAW},
      '{8'h00, 1'b0, NO_DRAW},
      '{8'hFF, 1'b0, NO_DRAW},
      // run row with swapped colors: longest repeat, one literal, end
      '{OP_RUN_V, 1'b0, NO_DRAW},
      '{8'h80, 1'b0, NO_DRAW},
      '{8'h7F, 1'b0, NO_DRAW},
      '{8'hFF, 1'b0, NO_DRAW},
      '{8'h00, 1'b0, NO_DRAW},
      '{RUN_REP_BASE + 8'd95, 1'b0, NO_DRAW},
      '{8'h0F, 1'b0, NO_DRAW},
      '{8'h01, 1'b0, NO_DRAW},
      '{8'hC3, 1'b0, NO_DRAW},
      '{RUN_END, 1'b0, NO_DRAW}
    };
    foreach (dir_tab[i]) byte_stream.push_back(dir_tab[i]);
    while (byte_stream.size() < DIR_ROWS + RANDOM_BYTES) add_random_command();
    // unknown opcode halts the decoder, so it closes the run; trailing bytes are dropped
    bad_op = 8'($urandom);
    while (bad_op inside {OP_SYNC, OP_RECT, OP_LIT_H, OP_LIT_V, OP_HFILL, OP_VFILL,
                          OP_RUN_H, OP_RUN_V})
      bad_op = 8'($urandom);
    push_byte(bad_op);
    repeat (3) push_byte(rand_glyph());

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    while (feed_idx < byte_stream.size() || pending_draws.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

endmodule
